// ===== hw/rtl/euclidean_distance_with_cutoff_assert.svh =====
// assertion macros for the checker file
`ifndef EUCLIDEAN_DISTANCE_WITH_CUTOFF_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_WITH_CUTOFF_ASSERT_SVH

// concurrent check clocked on aclk, off while in reset
`define EDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check clocked on aclk, live during reset too
`define EDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/edc_pkg.sv =====
// shared constants and types of the euclidean distance block
package edc_pkg;

    localparam int SAMPLE_W        = 16;  // field width of each sample
    localparam int SAMPLE_BITS_DEF = 16;  // significant sample bits by default
    localparam int SUM_W           = 48;  // saturating accumulator width
    localparam int ROOT_W          = SUM_W / 2;
    localparam int QUEUE_DEPTH     = 4;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             exceeded;
    } edc_job_t;

    typedef struct packed {
        logic     valid;
        edc_job_t job;
    } edc_push_t;

endpackage

// ===== hw/rtl/euclidean_distance_with_cutoff.sv =====
// path: mag1_reg, sq2_reg, frame queue, bit-serial root, output register
// throughput: one sample word per cycle unless a frame end meets a full queue;
//   the bit-serial root unit takes one sum at a time, a 4-entry queue absorbs short frames
// exceeded frames skip the root and go straight to the output register
// reset: synchronous active-low aresetn clears the sum, cutoff, queue and valids
module euclidean_distance_with_cutoff
    import edc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input word stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // sample_a [15:0], sample_b [31:16]
    input  logic                s_tlast,   // last_element
    // result word stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // distance [23:0]
    output logic [0:0]          m_tuser,   // exceeded [0]
    // cutoff_squared register
    input  logic                cfg_we,
    input  logic [SUM_W-1:0]    cfg_wdata
);

    logic [SUM_W-1:0] cutoff_reg;
    edc_push_t        push;
    logic             q_full, q_not_empty, q_pop;
    edc_job_t         q_head;
    logic [ROOT_W-1:0] distance;
    logic             exceeded;

    // zero disables the cutoff test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= '0;
        end else if (cfg_we) begin
            cutoff_reg <= cfg_wdata;
        end
    end

    // front: difference, square, saturating accumulate, cutoff compare
    edc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .sample_a     (s_tdata[SAMPLE_W-1:0]),
        .sample_b     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .last_element (s_tlast),
        .cutoff       (cutoff_reg),
        .push         (push),
        .q_full       (q_full)
    );

    // finished frame sums wait here for the root unit
    edc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: square root and output register
    edc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_distance  (distance),
        .m_exceeded  (exceeded)
    );

    assign m_tdata    = distance;
    assign m_tuser[0] = exceeded;

endmodule

// ===== hw/rtl/edc_queue.sv =====
// short queue of finished frame sums between front and back
module edc_queue
    import edc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  edc_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output edc_job_t  head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    edc_job_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                mem_reg[wr_ptr_reg] <= push.job;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/edc_front.sv =====
// front: squared difference pipeline, saturating sum and cutoff test
module edc_front
    import edc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_a,
    input  logic [SAMPLE_W-1:0] sample_b,
    input  logic                last_element,
    input  logic [SUM_W-1:0]    cutoff,
    output edc_push_t           push,
    input  logic                q_full
);

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                   v1_reg, v2_reg, last1_reg, last2_reg;
    logic [SAMPLE_BITS-1:0] mag1_reg;
    logic [SQ_W-1:0]        sq2_reg;
    logic [SUM_W-1:0]       sum_reg;

    logic signed [SAMPLE_BITS:0] diff, diff_neg;
    logic [SAMPLE_BITS-1:0]      mag;
    logic [SUM_W:0]              total_wide;
    logic [SUM_W-1:0]            total;
    logic                        en;

    // whole pipe stalls only when a frame end meets a full queue
    assign en       = !(v2_reg && last2_reg && q_full);
    assign in_ready = en;

    always_comb begin
        diff = $signed({sample_a[SAMPLE_BITS-1], sample_a[SAMPLE_BITS-1:0]})
             - $signed({sample_b[SAMPLE_BITS-1], sample_b[SAMPLE_BITS-1:0]});
        diff_neg = -diff;
        mag = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
        total_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq2_reg);
        total = total_wide[SUM_W] ? '1 : total_wide[SUM_W-1:0];
    end

    always_comb begin
        push.valid        = v2_reg && last2_reg && en;
        push.job.sum      = total;
        push.job.exceeded = (cutoff != '0) && (total > cutoff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sum_reg <= '0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                sum_reg <= last2_reg ? '0 : total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag;
            last1_reg <= last_element;
            sq2_reg   <= SQ_W'(mag1_reg * mag1_reg);
            last2_reg <= last1_reg;
        end
    end

endmodule

// ===== hw/rtl/edc_back.sv =====
// back: bit-serial integer square root and result register
module edc_back
    import edc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  edc_job_t          q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROOT_W-1:0] m_distance,
    output logic              m_exceeded
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROOT,
        B_HOLD
    } state_t;

    state_t             state_reg;
    logic [SUM_W-1:0]   x_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               exc_reg;
    logic               m_valid_reg;
    logic [ROOT_W-1:0]  m_distance_reg;
    logic               m_exceeded_reg;

    logic [REM_W+1:0]   rem_sh, trial;
    logic               fits;
    logic [REM_W-1:0]   rem_next;
    logic [ROOT_W-1:0]  root_next;
    logic               out_load;

    assign q_pop      = (state_reg == B_IDLE) && q_not_empty;
    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_exceeded = m_exceeded_reg;

    // finished root moves into the output register when it is free
    assign out_load   = (state_reg == B_HOLD) && (!m_valid_reg || m_ready);

    // one root bit per cycle, two radicand bits brought down each time
    always_comb begin
        rem_sh    = {rem_reg, x_reg[SUM_W-1 -: 2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        fits      = (rem_sh >= trial);
        rem_next  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_next = {root_reg[ROOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_not_empty) begin
                        x_reg    <= q_head.sum;
                        exc_reg  <= q_head.exceeded;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= CNT_W'(ROOT_W - 1);
                        state_reg <= q_head.exceeded ? B_HOLD : B_ROOT;
                    end
                end
                B_ROOT: begin
                    x_reg    <= {x_reg[SUM_W-3:0], 2'b00};
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (out_load) begin
                        m_distance_reg <= exc_reg ? '0 : root_reg;
                        m_exceeded_reg <= exc_reg;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/edc_checker.sv =====
// port-level checks on the euclidean distance block, bound to the top level
`include "euclidean_distance_with_cutoff_assert.svh"

module edc_checker
    import edc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [31:0]      s_tdata,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [23:0]      m_tdata,
    input logic [0:0]       m_tuser,
    input logic             cfg_we,
    input logic [SUM_W-1:0] cfg_wdata
);

    // a stalled result word keeps its place and contents
    `EDC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word dropped or changed while stalled")

    // an exceeded result never carries a distance
    `EDC_ASSERT(a_exc_zero, m_tvalid && m_tuser[0] |-> m_tdata == 24'd0, "exceeded result with nonzero distance")

    // a result word never rises too soon after reset is released
    `EDC_ASSERT(a_out_after_input, $rose(m_tvalid) |-> $past(!aresetn, 3) == 1'b0, "result word too soon after reset")

    // nothing is shown in the cycle after reset
    `EDC_ASSERT_ALWAYS(a_reset_clear, $past(!aresetn) |-> !m_tvalid, "result valid right after reset")

endmodule

bind euclidean_distance_with_cutoff edc_checker u_edc_checker (.*);

// ===== dv/euclidean_distance_with_cutoff_tb.sv =====
// testbench for euclidean_distance_with_cutoff: random frames checked against a built-in predictor

class distance_scoreboard;

    typedef struct {
        logic [23:0] distance;
        logic        exceeded;
    } frame_result_t;

    frame_result_t expected_results[$];
    logic [47:0]   running_sum;
    logic [47:0]   cutoff;
    int            sample_bits;
    int            pairs_seen;
    int            frames_checked;
    int            exceeded_seen;
    int            errors;

    function new(int bits);
        sample_bits    = bits;
        running_sum    = '0;
        cutoff         = '0;
        pairs_seen     = 0;
        frames_checked = 0;
        exceeded_seen  = 0;
        errors         = 0;
    endfunction

    function void set_cutoff(logic [47:0] value);
        cutoff = value;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // low sample_bits of the field, read as two's complement
    function longint sample_value(logic [15:0] raw);
        longint span;
        longint v;
        span = longint'(1) << sample_bits;
        v    = longint'(raw) & (span - 1);
        if (v >= (span >> 1)) begin
            v = v - span;
        end
        return v;
    endfunction

    // floor of the square root, one result bit per pass from the top
    function logic [23:0] floor_root(logic [47:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {16'd0, x}) begin
                root = trial;
            end
        end
        return root[23:0];
    endfunction

    // one accepted sample word: accumulate, and on last queue the frame result
    function void note_pair(logic [15:0] a, logic [15:0] b, logic last);
        longint        diff;
        logic   [63:0] mag;
        logic   [63:0] total;
        frame_result_t res;
        diff  = sample_value(a) - sample_value(b);
        mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
        total = {16'd0, running_sum} + mag * mag;
        if (total > 64'hFFFF_FFFF_FFFF) begin
            total = 64'hFFFF_FFFF_FFFF;
        end
        pairs_seen++;
        if (!last) begin
            running_sum = total[47:0];
            return;
        end
        running_sum = '0;
        if (cutoff != 0 && total[47:0] > cutoff) begin
            res.distance = '0;
            res.exceeded = 1'b1;
        end else begin
            res.distance = floor_root(total[47:0]);
            res.exceeded = 1'b0;
        end
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [23:0] distance, logic exceeded);
        frame_result_t want;
        if (expected_results.size() == 0) begin
            $error("result word with nothing expected: distance %0d exceeded %0d",
                   distance, exceeded);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        frames_checked++;
        if (want.exceeded) begin
            exceeded_seen++;
        end
        if (distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, distance);
            errors++;
        end
        if (exceeded !== want.exceeded) begin
            $error("exceeded: expected %0d, actual %0d", want.exceeded, exceeded);
            errors++;
        end
    endfunction

endclass

module euclidean_distance_with_cutoff_tb;
    import edc_pkg::*;

    localparam int TB_SAMPLE_BITS = 16;
    localparam int SETTLE_CYCLES  = 40;     // covers the root pass and output stage
    localparam int HOLD_CYCLES    = 400;    // long receiver stall
    localparam int STALL_LIMIT    = 5000;   // cycles without any handshake
    localparam int LONG_FRAME     = 64;     // full-swing pairs in one long frame
    localparam int PHASE_ITEMS    = 140;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;     // sample_a [15:0], sample_b [31:16]
    logic              s_tlast;     // last_element
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;     // distance [23:0]
    logic [0:0]        m_tuser;     // exceeded [0]
    logic              cfg_we;
    logic [SUM_W-1:0]  cfg_wdata;

    distance_scoreboard sb;

    bit hold_request;
    int send_steady;
    int recv_steady;
    int idle_cycles;

    euclidean_distance_with_cutoff #(
        .SAMPLE_BITS (TB_SAMPLE_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle cycles before the next word, with runs of back-to-back words
    function automatic int draw_gap(ref int steady);
        if (steady > 0) begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            steady = $urandom_range(4, 24);
        end
        return $urandom_range(0, 16);
    endfunction

    // full range, small values and the two extremes
    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(a, b, last);
    endtask

    task automatic send_random_frame(int len);
        for (int i = 0; i < len; i++) begin
            send_pair(draw_sample(), draw_sample(), i == len - 1, draw_gap(send_steady));
        end
    endtask

    // drop valid, drain every result, then let the pipe settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cutoff(logic [47:0] value);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_cutoff(value);
    endtask

    task automatic receive_results();
        int wait_n;
        forever begin
            if (hold_request) begin
                // long stall so the frame queue fills and input backs up
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                wait_n = draw_gap(recv_steady);
                if (wait_n > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser[0]);
        end
    endtask

    initial begin
        int          sent;
        int          len;
        logic [47:0] phase_cutoff;

        sb           = new(TB_SAMPLE_BITS);
        hold_request = 1'b0;
        send_steady  = 0;
        recv_steady  = 0;
        idle_cycles  = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fork
            receive_results();
        join_none

        // cutoff off: extremes, zero, single-pair and multi-pair frames
        write_cutoff(48'd0);
        send_pair(16'h7FFF, 16'h8000, 1'b1, 0);
        send_pair(16'h8000, 16'h7FFF, 1'b1, 3);
        send_pair(16'h0000, 16'h0000, 1'b1, 0);
        send_pair(16'hFFFF, 16'h0001, 1'b1, 1);
        send_pair(16'h0003, 16'h0000, 1'b0, 0);
        send_pair(16'h0000, 16'hFFFC, 1'b0, 2);
        send_pair(16'h8000, 16'h8000, 1'b1, 0);

        // cutoff 9: sum equal passes, sum above is flagged
        write_cutoff(48'd9);
        send_pair(16'h0003, 16'h0000, 1'b1, 0);
        send_pair(16'h0003, 16'h0001, 1'b1, 0);
        send_pair(16'h0004, 16'h0000, 1'b1, 4);
        send_pair(16'h0002, 16'h0000, 1'b0, 0);
        send_pair(16'h0000, 16'h0002, 1'b0, 0);
        send_pair(16'h0001, 16'h0000, 1'b1, 0);

        // cutoff 1: everything above one is flagged
        write_cutoff(48'd1);
        send_pair(16'h0001, 16'h0000, 1'b1, 0);
        send_pair(16'h0000, 16'h0000, 1'b1, 0);
        send_pair(16'h8000, 16'h7FFF, 1'b1, 0);

        // full-scale cutoff with a long full-swing frame: large sum, never flagged
        write_cutoff(48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < LONG_FRAME; i++) begin
            send_pair(16'h7FFF, 16'h8000, i == LONG_FRAME - 1, 0);
        end

        // random frames under several cutoff settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: phase_cutoff = 48'd0;
                1: phase_cutoff = {14'd0, 2'($urandom), 32'($urandom)};
                2: phase_cutoff = 48'hFFFF_FFFF_FFFF;
                3: phase_cutoff = 48'd1;
                default: phase_cutoff = {16'($urandom), 32'($urandom)};
            endcase
            write_cutoff(phase_cutoff);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 6);
                send_random_frame(len);
                sent += len;
            end
        end

        // receiver stalls for a long time while single-pair frames keep coming
        write_cutoff({14'd0, 2'($urandom), 32'($urandom)});
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_pair(draw_sample(), draw_sample(), 1'b1, 0);
        end

        quiesce();

        $display("checked %0d frame results from %0d sample words, %0d over the cutoff",
                 sb.frames_checked, sb.pairs_seen, sb.exceeded_seen);
        $display("cutoffs zero, one, full scale and random; one long full-swing frame; one long stall");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
